>>> design/mf1_pkg.sv
// ============================================================================
// mf1_pkg: shared types and constants of the macro F1 score engine
// Holds the item kinds, result kinds, sequencer states, the register address and the default sizes.
// ============================================================================
`default_nettype none
package mf1_pkg;
  localparam int unsigned MaxClassesDef = 64;
  localparam int unsigned CountBitsDef  = 32;
  localparam logic [6:0]  ClassCountRst = 7'd10;

  typedef enum logic [1:0] {
    KIND_SCORE  = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    RES_ROW    = 1'b0,
    RES_REPORT = 1'b1
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_RP_RD,
    ST_RP_WAIT,
    ST_RP_PDIV,
    ST_RP_RDIV,
    ST_RP_NEXT,
    ST_AVG_P,
    ST_AVG_R,
    ST_F1,
    ST_OUT
  } state_e;

  localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
endpackage
`default_nettype wire

>>> design/mf1_ram.sv
// ============================================================================
// mf1_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
`default_nettype none
module mf1_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> design/mf1_div.sv
// ============================================================================
// mf1_div: shared restoring divider
// Computes num/den one quotient bit per cycle, NumBits steps.
// ============================================================================
`default_nettype none
module mf1_div #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 40,
  parameter int unsigned QBits   = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    busy_o,
  output logic [QBits-1:0]        quot_o
);
  localparam int unsigned Steps = NumBits;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned RemW  = DenBits + 1;

  logic [RemW-1:0]    rem_q, rem_d;
  logic [NumBits-1:0] num_q, num_d;
  logic [QBits-1:0]   quot_q, quot_d;
  logic [DenBits-1:0] den_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [RemW-1:0]    shifted;

  assign shifted = {rem_q[RemW-2:0], num_q[NumBits-1]};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      quot_d = '0;
      cnt_d  = CntW'(Steps);
    end else if (cnt_q != '0) begin
      num_d = {num_q[NumBits-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[QBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[QBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule
`default_nettype wire

>>> design/macro_f1_score_engine_core.sv
// ============================================================================
// macro_f1_score_engine_core: macro averaged F1 score engine
// Row argmax tracking, saturating confusion counters and a report sequencer.
// ============================================================================
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one transaction with kind,
//    pred_score and target_score. Output channel (out_valid_o / out_stall_i)
//    returns row verdicts and reports, each held while stalled.
//  - A score element that does not end a row only updates the row position and the running
//    argmax. A row-ending element runs a counter read, a write back and the output register
//    step on a hit, and on a miss a read and write back of the predicted row, then of
//    the true row, then the output register step. The output register stays full
//    until taken; no new transaction is taken meanwhile.
//  - A report walks the classes: per class a counter read, a wait step, two
//    ratio steps and an advance step. A ratio step that divides uses the single
//    shared restoring divider. Two averaging steps and one F1 step, which also
//    use that divider, follow, then the output register. DivBits, the divider
//    width, is COUNT_BITS+32 by default.
//  - Clear and reset zero the counters with a pass over all MAX_CLASSES entries of
//    the counter memory, one entry a cycle; in_stall_o is high during the pass.
//  - The class count register is written through the APB port at address 0;
//    write it only while idle (the block itself does not enforce this).
// ============================================================================
`default_nettype none
module macro_f1_score_engine_core
  import mf1_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MaxClassesDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic signed [31:0] pred_score_i,
  input  wire logic signed [31:0] target_score_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [5:0]       pred_idx_o,
  output logic [5:0]       true_idx_o,
  output logic             correct_o,
  output logic [16:0]      precision_q16_o,
  output logic [16:0]      recall_q16_o,
  output logic [16:0]      f1_q16_o,
  output logic [6:0]       precision_classes_o,
  output logic [6:0]       recall_classes_o
);
  localparam int unsigned AW      = $clog2(MAX_CLASSES);
  localparam int unsigned CW      = $clog2(MAX_CLASSES + 1);
  localparam int unsigned DenW    = COUNT_BITS + 1;
  localparam int unsigned SumW    = 33 + AW;
  localparam int unsigned NumW    = COUNT_BITS + 32;
  localparam int unsigned DivBits = (NumW > SumW) ? NumW : SumW;
  localparam int unsigned RowW    = 3 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  // APB register
  logic [6:0] cls_count_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_count_q <= ClassCountRst;
    end else if (psel && penable && pwrite && paddr == REG_CLASS_COUNT) begin
      cls_count_q <= pwdata[6:0];
    end
  end
  assign prdata = (paddr == REG_CLASS_COUNT) ? {25'd0, cls_count_q} : 32'd0;

  // effective class count clamped to [2, MAX_CLASSES]
  logic [CW-1:0] eff_n;
  always_comb begin
    if (cls_count_q < 7'd2) begin
      eff_n = CW'(2);
    end else if (32'(cls_count_q) > MAX_CLASSES) begin
      eff_n = CW'(MAX_CLASSES);
    end else begin
      eff_n = CW'(cls_count_q);
    end
  end

  state_e state_q, state_d;

  // counter memory, one row per class: {tp, fp, fn}
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [RowW-1:0]   ram_wdata, ram_rdata;
  mf1_ram #(.Width(RowW), .Depth(MAX_CLASSES)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [COUNT_BITS-1:0] rd_tp, rd_fp, rd_fn;
  assign rd_tp = ram_rdata[RowW-1 -: COUNT_BITS];
  assign rd_fp = ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
  assign rd_fn = ram_rdata[COUNT_BITS-1:0];

  // shared divider
  logic               div_start, div_busy;
  logic [DivBits-1:0] div_num, div_den, div_quot;
  mf1_div #(.NumBits(DivBits), .DenBits(DivBits), .QBits(DivBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  // row state
  logic [CW-1:0] row_pos_q;
  logic [31:0]   best_p_q, best_t_q;
  logic [AW-1:0] best_pi_q, best_ti_q;
  logic [AW-1:0] pc_q, tc_q;
  logic [AW-1:0] cls_q;
  logic [AW:0]   clr_q;
  logic [SumW-1:0] psum_q, rsum_q;
  logic [CW-1:0]   pv_q, rv_q;
  logic [16:0]     p16_q, r16_q;
  logic [COUNT_BITS-1:0] tp_q, fp_q, fn_q;
  logic            rp_last_q;

  // output register
  logic        ov_q;
  logic        okind_q, ocorr_q;
  logic [5:0]  opc_q, otc_q;
  logic [16:0] op_q, or_q, of_q;
  logic [6:0]  opv_q, orv_q;

  logic in_acc, out_acc;
  assign in_stall_o = !(state_q == ST_IDLE && !ov_q);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = ov_q && !out_stall_i;

  logic [31:0] ps_b, ts_b;
  assign ps_b = pred_score_i ^ 32'h8000_0000;
  assign ts_b = target_score_i ^ 32'h8000_0000;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (kind_i == KIND_SCORE) begin
            if (row_pos_q + CW'(1) >= eff_n) state_d = ST_ROW_RD;
          end else if (kind_i == KIND_REPORT) begin
            state_d = ST_RP_RD;
          end else if (kind_i == KIND_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLEAR:   if (clr_q == (AW+1)'(MAX_CLASSES - 1)) state_d = ST_IDLE;
      ST_ROW_RD:  state_d = ST_ROW_WR;
      ST_ROW_WR:  state_d = (pc_q != tc_q && !miss_phase_q) ? ST_ROW_RD : ST_OUT;
      ST_RP_RD:   state_d = ST_RP_WAIT;
      ST_RP_WAIT: state_d = ST_RP_PDIV;
      ST_RP_PDIV: if (!div_busy && !div_start) state_d = ST_RP_RDIV;
      ST_RP_RDIV: if (!div_busy && !div_start) state_d = ST_RP_NEXT;
      ST_RP_NEXT: state_d = rp_last_q ? ST_AVG_P : ST_RP_RD;
      ST_AVG_P:   if (!div_busy && !div_start) state_d = ST_AVG_R;
      ST_AVG_R:   if (!div_busy && !div_start) state_d = ST_F1;
      ST_F1:      if (!div_busy && !div_start) state_d = ST_OUT;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // divider launch: a one-cycle start pulse on entry to each divide state whose operands call for a divide
  logic started_q;
  logic [DenW-1:0] dp_sum, dr_sum;
  assign dp_sum = {1'b0, tp_q} + {1'b0, fp_q};
  assign dr_sum = {1'b0, tp_q} + {1'b0, fn_q};

  logic [16:0] f1_num_pr;
  logic [33:0] f1_prod;
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '1;
    unique case (state_q)
      ST_RP_PDIV: begin
        div_start = !started_q && dp_sum != '0 && tp_q != '0 && fp_q != '0;
        div_num   = DivBits'({tp_q, 32'd0});
        div_den   = DivBits'(dp_sum);
      end
      ST_RP_RDIV: begin
        div_start = !started_q && dr_sum != '0 && tp_q != '0 && fn_q != '0;
        div_num   = DivBits'({tp_q, 32'd0});
        div_den   = DivBits'(dr_sum);
      end
      ST_AVG_P: begin
        div_start = !started_q && pv_q != '0;
        div_num   = DivBits'(psum_q);
        div_den   = DivBits'(pv_q);
      end
      ST_AVG_R: begin
        div_start = !started_q && rv_q != '0;
        div_num   = DivBits'(rsum_q);
        div_den   = DivBits'(rv_q);
      end
      ST_F1: begin
        div_start = !started_q && (p16_q != '0 || r16_q != '0);
        div_num   = DivBits'(f1_prod);
        div_den   = DivBits'({1'b0, p16_q} + {1'b0, r16_q});
      end
      default: ;
    endcase
  end
  assign f1_num_pr = p16_q;
  // 2*p*r from the settled averages
  assign f1_prod   = 34'({f1_num_pr, 1'b0} * r16_q);

  // class ratio: exact 1.0 when no misses, 0 when no hits, else divider result
  logic [32:0] ratio_p, ratio_r;
  assign ratio_p = (fp_q == '0) ? 33'h1_0000_0000 :
                   (tp_q == '0) ? 33'd0 : 33'(div_quot);
  assign ratio_r = (fn_q == '0) ? 33'h1_0000_0000 :
                   (tp_q == '0) ? 33'd0 : 33'(div_quot);

  logic [COUNT_BITS-1:0] inc_tp, inc_fp, inc_fn;
  assign inc_tp = (rd_tp == CntMax) ? rd_tp : rd_tp + COUNT_BITS'(1);
  assign inc_fp = (rd_fp == CntMax) ? rd_fp : rd_fp + COUNT_BITS'(1);
  assign inc_fn = (rd_fn == CntMax) ? rd_fn : rd_fn + COUNT_BITS'(1);

  // memory port control: a hit updates one row; a miss updates two rows, the
  // predicted row in ROW_RD/ROW_WR via read-modify-write and the true row after
  logic miss_phase_q;
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cls_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q[AW-1:0];
      end
      ST_ROW_RD: ram_addr = miss_phase_q ? tc_q : pc_q;
      ST_ROW_WR: begin
        ram_we = 1'b1;
        if (pc_q == tc_q) begin
          ram_addr  = pc_q;
          ram_wdata = {inc_tp, rd_fp, rd_fn};
        end else if (!miss_phase_q) begin
          ram_addr  = pc_q;
          ram_wdata = {rd_tp, inc_fp, rd_fn};
        end else begin
          ram_addr  = tc_q;
          ram_wdata = {rd_tp, rd_fp, inc_fn};
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      row_pos_q    <= '0;
      ov_q         <= 1'b0;
      started_q    <= 1'b0;
      miss_phase_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= (state_d == state_q) && (started_q || div_start);
      // fill the output register on the last sequencer step, drop it when taken
      if (state_q == ST_OUT) begin
        ov_q <= 1'b1;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          clr_q <= '0;
          if (in_acc && kind_i == KIND_SCORE) begin
            row_pos_q <= (row_pos_q + CW'(1) >= eff_n) ? '0 : row_pos_q + CW'(1);
          end else if (in_acc && kind_i == KIND_CLEAR) begin
            row_pos_q <= '0;
          end
        end
        ST_CLEAR: clr_q <= clr_q + (AW+1)'(1);
        ST_ROW_WR: miss_phase_q <= (pc_q != tc_q && !miss_phase_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && kind_i == KIND_SCORE) begin
      if (row_pos_q == '0) begin
        best_p_q  <= ps_b;
        best_t_q  <= ts_b;
        best_pi_q <= '0;
        best_ti_q <= '0;
        pc_q      <= '0;
        tc_q      <= '0;
      end else begin
        pc_q <= (ps_b > best_p_q) ? row_pos_q[AW-1:0] : best_pi_q;
        tc_q <= (ts_b > best_t_q) ? row_pos_q[AW-1:0] : best_ti_q;
        if (ps_b > best_p_q) begin
          best_p_q  <= ps_b;
          best_pi_q <= row_pos_q[AW-1:0];
        end
        if (ts_b > best_t_q) begin
          best_t_q  <= ts_b;
          best_ti_q <= row_pos_q[AW-1:0];
        end
      end
    end
    if (state_q == ST_IDLE && in_acc && kind_i == KIND_CLEAR) begin
      best_p_q  <= '0;
      best_t_q  <= '0;
      best_pi_q <= '0;
      best_ti_q <= '0;
    end
    if (state_q == ST_ROW_WR && !(pc_q != tc_q && !miss_phase_q)) begin
      okind_q <= RES_ROW;
      opc_q   <= 6'(pc_q);
      otc_q   <= 6'(tc_q);
      ocorr_q <= (pc_q == tc_q);
      op_q    <= '0;
      or_q    <= '0;
      of_q    <= '0;
      opv_q   <= '0;
      orv_q   <= '0;
    end
    if (state_q == ST_IDLE && in_acc && kind_i == KIND_REPORT) begin
      cls_q     <= '0;
      rp_last_q <= (eff_n == CW'(1));
      psum_q    <= '0;
      rsum_q    <= '0;
      pv_q      <= '0;
      rv_q      <= '0;
      p16_q     <= '0;
      r16_q     <= '0;
    end
    if (state_q == ST_RP_WAIT) begin
      tp_q <= rd_tp;
      fp_q <= rd_fp;
      fn_q <= rd_fn;
    end
    if (state_q == ST_RP_PDIV && state_d != ST_RP_PDIV && dp_sum != '0) begin
      psum_q <= psum_q + SumW'(ratio_p);
      pv_q   <= pv_q + CW'(1);
    end
    if (state_q == ST_RP_RDIV && state_d != ST_RP_RDIV && dr_sum != '0) begin
      rsum_q <= rsum_q + SumW'(ratio_r);
      rv_q   <= rv_q + CW'(1);
    end
    if (state_q == ST_RP_NEXT) begin
      cls_q     <= cls_q + AW'(1);
      rp_last_q <= ({1'b0, cls_q} + (AW+1)'(2) >= (AW+1)'(eff_n));
    end
    if (state_q == ST_AVG_P && state_d != ST_AVG_P && pv_q != '0) begin
      p16_q <= 17'(div_quot >> 16);
    end
    if (state_q == ST_AVG_R && state_d != ST_AVG_R && rv_q != '0) begin
      r16_q <= 17'(div_quot >> 16);
    end
    if (state_q == ST_F1 && state_d != ST_F1) begin
      okind_q <= RES_REPORT;
      opc_q   <= '0;
      otc_q   <= '0;
      ocorr_q <= 1'b0;
      op_q    <= p16_q;
      or_q    <= r16_q;
      of_q    <= (p16_q != '0 || r16_q != '0) ? 17'(div_quot) : '0;
      opv_q   <= 7'(pv_q);
      orv_q   <= 7'(rv_q);
    end
  end

  assign out_valid_o         = ov_q;
  assign result_kind_o       = okind_q;
  assign pred_idx_o          = opc_q;
  assign true_idx_o          = otc_q;
  assign correct_o           = ocorr_q;
  assign precision_q16_o     = op_q;
  assign recall_q16_o        = or_q;
  assign f1_q16_o            = of_q;
  assign precision_classes_o = opv_q;
  assign recall_classes_o    = orv_q;

  // a finished result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q) else $error("result dropped while stalled");
  // no new transaction while a result waits
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> in_stall_o) else $error("accept with full output register");
  // the divider is idle whenever the sequencer is idle
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_busy) else $error("divider busy in idle");
endmodule
`default_nettype wire
